// ----- hw/rtl/hktt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hktt_pkg
// Types and constants shared by the housekeeping tick timer modules.
// ----------------------------------------------------------------------------
package hktt_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned SubsecW = 7;
  localparam int unsigned MinTickW = 13;
  localparam int unsigned LedW    = 8;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [SubsecW-1:0]  TicksPerSecond = SubsecW'(100);
  localparam logic [MinTickW-1:0] TicksPerMinute = MinTickW'(6000);
  localparam logic [CountW-1:0]   CountMax       = {CountW{1'b1}};

  localparam logic [CountW-1:0] LivePeriodReset = CountW'(60);
  localparam logic [CountW-1:0] AdcPeriodReset  = CountW'(100);

  typedef enum logic [CfgIdxW-1:0] {
    CfgLivePeriod = 1'b0,
    CfgAdcPeriod  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] live_period_seconds;
    logic [CountW-1:0] adc_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] stalled_mask;
    logic             adc_divider_reset;
    logic             query_clear;
    logic             strobe_clear;
    logic             green_load_valid;
    logic [LedW-1:0]  green_load_ticks;
    logic             red_load_valid;
    logic [LedW-1:0]  red_load_ticks;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]  period_clear_mask;
    logic [CountW-1:0] query_interval;
    logic [CountW-1:0] strobe_interval;
    logic              live_due;
    logic [CountW-1:0] uptime_minutes_out;
    logic              adc_sample;
    logic              green_lit;
    logic              red_lit;
  } out_item_t;

endpackage

// ----- hw/rtl/hktt_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hktt_core
// Timer state and the single-pass update for one tick item.
// ----------------------------------------------------------------------------
module hktt_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  hktt_pkg::in_item_t item_i,
  input  hktt_pkg::cfg_t     cfg_i,
  output hktt_pkg::out_item_t result_o
);

  logic [hktt_pkg::SubsecW-1:0]  sub_q, sub_d, sub_inc;
  logic [hktt_pkg::CountW-1:0]   sec_q, sec_d, sec_inc;
  logic [hktt_pkg::MinTickW-1:0] mtick_q, mtick_d, mtick_inc;
  logic [hktt_pkg::CountW-1:0]   upmin_q, upmin_d;
  logic [hktt_pkg::CountW-1:0]   adc_q, adc_d, adc_inc;
  logic [hktt_pkg::CountW-1:0]   query_q, query_d, query_base;
  logic [hktt_pkg::CountW-1:0]   strobe_q, strobe_d, strobe_base;
  logic [hktt_pkg::LedW-1:0]     green_q, green_d, green_base;
  logic [hktt_pkg::LedW-1:0]     red_q, red_d, red_base;
  logic sec_wrap, min_wrap, live, adc_hit, glit, rlit;

  always_comb begin
    query_base  = item_i.query_clear ? '0 : query_q;
    strobe_base = item_i.strobe_clear ? '0 : strobe_q;
    query_d  = (query_base == hktt_pkg::CountMax) ? query_base : query_base + 1'b1;
    strobe_d = (strobe_base == hktt_pkg::CountMax) ? strobe_base : strobe_base + 1'b1;

    sub_inc  = sub_q + 1'b1;
    sec_wrap = (sub_inc == hktt_pkg::TicksPerSecond);
    sub_d    = sec_wrap ? '0 : sub_inc;
    sec_inc  = sec_q + 1'b1;
    live     = sec_wrap && (sec_inc >= cfg_i.live_period_seconds);
    sec_d    = sec_wrap ? (live ? '0 : sec_inc) : sec_q;

    mtick_inc = mtick_q + 1'b1;
    min_wrap  = (mtick_inc == hktt_pkg::TicksPerMinute);
    mtick_d   = min_wrap ? '0 : mtick_inc;
    upmin_d   = (min_wrap && (upmin_q != hktt_pkg::CountMax)) ? upmin_q + 1'b1 : upmin_q;

    adc_inc = (item_i.adc_divider_reset ? '0 : adc_q) + 1'b1;
    adc_hit = (adc_inc == cfg_i.adc_period_ticks);
    adc_d   = adc_hit ? '0 : adc_inc;

    green_base = item_i.green_load_valid ? item_i.green_load_ticks : green_q;
    red_base   = item_i.red_load_valid ? item_i.red_load_ticks : red_q;
    glit    = (green_base != '0);
    rlit    = (red_base != '0);
    green_d = glit ? green_base - 1'b1 : green_base;
    red_d   = rlit ? red_base - 1'b1 : red_base;

    result_o.period_clear_mask  = item_i.stalled_mask;
    result_o.query_interval     = query_d;
    result_o.strobe_interval    = strobe_d;
    result_o.live_due           = live;
    result_o.uptime_minutes_out = upmin_d;
    result_o.adc_sample         = adc_hit;
    result_o.green_lit          = glit;
    result_o.red_lit            = rlit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q    <= '0;
      sec_q    <= '0;
      mtick_q  <= '0;
      upmin_q  <= '0;
      adc_q    <= '0;
      query_q  <= '0;
      strobe_q <= hktt_pkg::CountMax;
      green_q  <= '0;
      red_q    <= '0;
    end else if (step_i) begin
      sub_q    <= sub_d;
      sec_q    <= sec_d;
      mtick_q  <= mtick_d;
      upmin_q  <= upmin_d;
      adc_q    <= adc_d;
      query_q  <= query_d;
      strobe_q <= strobe_d;
      green_q  <= green_d;
      red_q    <= red_d;
    end
  end

endmodule

// ----- hw/rtl/housekeeping_tick_timers_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// housekeeping_tick_timers_unit
// Housekeeping tick timers: one 10 ms tick item in, one status item out.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless the input stalls; its result appears in the cycle
// after acceptance, set by the single update pass from the timer registers
// into the output register. Reset loads the timer state and the register
// defaults at once; no sweep. The input stalls only while a result waits in
// the output register and the output side stalls.
// ----------------------------------------------------------------------------
module housekeeping_tick_timers_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  hktt_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output hktt_pkg::out_item_t                out_item_o,
  input  logic                               cfg_we_i,
  input  logic [hktt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hktt_pkg::CountW-1:0]        cfg_wdata_i
);

  hktt_pkg::cfg_t      cfg_q;
  hktt_pkg::out_item_t result, out_item_q;
  logic                out_valid_q;
  logic                step;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign step        = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.live_period_seconds <= hktt_pkg::LivePeriodReset;
      cfg_q.adc_period_ticks    <= hktt_pkg::AdcPeriodReset;
    end else if (cfg_we_i) begin
      case (hktt_pkg::cfg_idx_e'(cfg_idx_i))
        hktt_pkg::CfgLivePeriod: cfg_q.live_period_seconds <= cfg_wdata_i;
        hktt_pkg::CfgAdcPeriod:  cfg_q.adc_period_ticks    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hktt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("accepted item produced no result");

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result is blocked");

  a_drain_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !in_valid_i) |=> !out_valid_o)
    else $error("result repeated after delivery");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");
`endif

endmodule
